### design/smmt_pkg.sv
`default_nettype none

package smmt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int RESULT_LIMIT = 16;
  localparam int KEY_W = 32;
  localparam int HID_W = 8;

  typedef enum logic [1:0] {
    CMD_MATCH         = 2'd0,
    CMD_SUB           = 2'd1,
    CMD_UNSUB_MASK    = 2'd2,
    CMD_UNSUB_HANDLER = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_NONE = 2'd2,
    STAT_ZERO = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_CLEAR,
    CELL_COMPACT,
    CELL_WRITE
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUB,
    S_MARK,
    S_COMPACT,
    S_MATCH,
    S_FINISH
  } fsm_t;

  typedef struct packed {
    logic [KEY_W-1:0] mask;
    logic [HID_W-1:0] handler;
  } entry_t;

  typedef struct packed {
    cell_op_t         op;
    logic [KEY_W-1:0] key;
    logic [HID_W-1:0] hid;
    logic             by_handler;
  } cell_ctl_t;

endpackage

`default_nettype wire

### design/subscription_mask_match_table_top.sv
`default_nettype none

// Subscription table with mask matching, built as a chain of entry cells.
// A request is taken at a rising edge where start is high and busy is low;
// it carries in_command, in_key and in_handler_id. Busy stays high until the
// request is finished, and only one request is worked on at a time.
// Results leave on the out_ ports, each valid for exactly one cycle while
// out_valid is high; the receiver cannot stall them, and out_last marks the
// final result of a request.
// Subscribe gives its single result from the S_SUB state, through the output register.
// Both unsubscribe commands first clear the selected entries in S_MARK, then
// TABLE_DEPTH compaction steps close the gaps, each step moving every entry
// behind the first hole one cell forward.
// A match rotates the whole chain once, one entry through the head cell per
// cycle; hits come out in table order, each one held back until the next hit
// or the end of the rotation so the final one can be flagged as last.
// The rotation and compaction set how often match and unsubscribe requests
// can be taken, as a new request waits until busy is low again.
// A synchronous active-low reset empties the table and aborts any request.
module subscription_mask_match_table_top #(
  parameter int TABLE_DEPTH = smmt_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_key,
  input  logic [7:0]  in_handler_id,
  output logic        out_valid,
  output logic [7:0]  out_handler_out,
  output logic        out_matched,
  output logic [1:0]  out_status,
  output logic        out_last
);
  import smmt_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH);
  localparam int KW = $clog2(RESULT_LIMIT + 1);

  fsm_t             state_r, state_nxt;
  cmd_t             cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [HID_W-1:0] hid_r;
  logic [CW-1:0]    cnt_r;
  logic [KW-1:0]    k_r;
  logic             pend_v_r;
  logic [HID_W-1:0] pend_h_r;
  logic             found_r;

  logic             out_valid_r;
  logic [HID_W-1:0] out_h_r;
  logic             out_m_r;
  status_t          out_st_r;
  logic             out_last_r;

  cell_ctl_t        ctl;
  entry_t           ent [TABLE_DEPTH];
  entry_t           nxt [TABLE_DEPTH];
  logic [TABLE_DEPTH:0]   hole;
  logic [TABLE_DEPTH-1:0] hits;

  logic             accept;
  logic             cnt_last;
  logic             full;
  logic             take;
  logic             res_valid;
  logic [HID_W-1:0] res_h;
  logic             res_m;
  status_t          res_st;
  logic             res_last;

  assign accept   = start && (state_r == S_IDLE);
  assign busy     = (state_r != S_IDLE);
  assign cnt_last = (cnt_r == CW'(TABLE_DEPTH - 1));
  assign full     = ~hole[TABLE_DEPTH];
  assign hole[0]  = 1'b0;

  // The chain: each cell is fed by its successor; the tail cell is fed by the
  // head cell during a match rotation and by an empty entry otherwise.
  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      if (gi == TABLE_DEPTH - 1) begin : g_tail
        assign nxt[gi] = (ctl.op == CELL_ROTATE) ? ent[0] : '0;
      end else begin : g_body
        assign nxt[gi] = ent[gi+1];
      end
      smmt_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .nxt_entry (nxt[gi]),
        .hole_in   (hole[gi]),
        .entry     (ent[gi]),
        .hole_out  (hole[gi+1]),
        .hit       (hits[gi])
      );
    end
  endgenerate

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (cmd_t'(in_command))
            CMD_MATCH: state_nxt = S_MATCH;
            CMD_SUB:   state_nxt = S_SUB;
            default:   state_nxt = S_MARK;
          endcase
        end
      end
      S_SUB:     state_nxt = S_IDLE;
      S_MARK:    state_nxt = S_COMPACT;
      S_COMPACT: if (cnt_last) state_nxt = S_IDLE;
      S_MATCH:   if (cnt_last) state_nxt = S_FINISH;
      S_FINISH:  state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Cell commands and result values for each state.
  always_comb begin
    ctl.op         = CELL_HOLD;
    ctl.key        = key_r;
    ctl.hid        = hid_r;
    ctl.by_handler = (cmd_r == CMD_UNSUB_HANDLER);
    take           = 1'b0;
    res_valid      = 1'b0;
    res_h          = '0;
    res_m          = 1'b0;
    res_st         = STAT_OK;
    res_last       = 1'b1;
    case (state_r)
      S_SUB: begin
        res_valid = 1'b1;
        if (key_r == '0) begin
          res_st = STAT_ZERO;
        end else if (full) begin
          res_st = STAT_FULL;
        end else begin
          ctl.op = CELL_WRITE;
        end
      end
      S_MARK: begin
        ctl.op = CELL_CLEAR;
      end
      S_COMPACT: begin
        ctl.op = CELL_COMPACT;
        if (cnt_last) begin
          res_valid = 1'b1;
          if ((cmd_r == CMD_UNSUB_MASK) && (key_r == '0)) begin
            res_st = STAT_ZERO;
          end else if (found_r) begin
            res_st = STAT_OK;
          end else begin
            res_st = STAT_NONE;
          end
        end
      end
      S_MATCH: begin
        ctl.op = CELL_ROTATE;
        take   = (ent[0].mask != '0) && ((ent[0].mask & key_r) == key_r) &&
                 (k_r < KW'(RESULT_LIMIT));
        // A new hit releases the one held back, which is then not the last.
        if (take && pend_v_r) begin
          res_valid = 1'b1;
          res_h     = pend_h_r;
          res_m     = 1'b1;
          res_last  = 1'b0;
        end
      end
      S_FINISH: begin
        res_valid = 1'b1;
        if (pend_v_r) begin
          res_h = pend_h_r;
          res_m = 1'b1;
        end else begin
          res_st = STAT_NONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      pend_v_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= res_valid;
      if (accept) begin
        cnt_r    <= '0;
        k_r      <= '0;
        pend_v_r <= 1'b0;
        found_r  <= 1'b0;
      end else begin
        if ((state_r == S_MATCH) || (state_r == S_COMPACT)) begin
          cnt_r <= cnt_r + CW'(1);
        end
        if (state_r == S_MARK) begin
          found_r <= |hits;
        end
        if (take) begin
          pend_v_r <= 1'b1;
          k_r      <= k_r + KW'(1);
        end else if (state_r == S_FINISH) begin
          pend_v_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_t'(in_command);
      key_r <= in_key;
      hid_r <= in_handler_id;
    end
    if (take) begin
      pend_h_r <= ent[0].handler;
    end
    out_h_r    <= res_h;
    out_m_r    <= res_m;
    out_st_r   <= res_st;
    out_last_r <= res_last;
  end

  assign out_valid       = out_valid_r;
  assign out_handler_out = out_h_r;
  assign out_matched     = out_m_r;
  assign out_status      = out_st_r;
  assign out_last        = out_last_r;

`ifndef SYNTH
  // A held-back hit never survives past the end of a match.
  a_pend_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_v_r)
    else $error("held-back match result left over in idle");

  // Only a match produces results that are not the final one.
  a_nonlast_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> ((state_r == S_MATCH) || (state_r == S_FINISH)))
    else $error("non-final result outside a match");

  // Every result follows a cycle in which a request was being worked on.
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) != S_IDLE))
    else $error("result produced without a request in progress");

  // A matching result always reports ok status.
  a_match_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_matched) |-> (out_status == STAT_OK))
    else $error("matching result with error status");
`endif

endmodule

`default_nettype wire

### design/smmt_cell.sv
`default_nettype none

module smmt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  smmt_pkg::cell_ctl_t ctl,
  input  smmt_pkg::entry_t   nxt_entry,
  input  logic               hole_in,
  output smmt_pkg::entry_t   entry,
  output logic               hole_out,
  output logic               hit
);
  import smmt_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;
  logic   empty;
  logic   first_free;

  assign empty      = (entry_r.mask == '0);
  assign hole_out   = hole_in | empty;
  assign first_free = empty & ~hole_in;
  assign hit        = ~empty & (ctl.by_handler ? (entry_r.handler == ctl.hid)
                                               : (entry_r.mask == ctl.key));
  assign entry      = entry_r;

  // A compaction step moves every entry behind the first hole up by one.
  always_comb begin
    entry_nxt = entry_r;
    case (ctl.op)
      CELL_ROTATE:  entry_nxt = nxt_entry;
      CELL_COMPACT: if (hole_out) entry_nxt = nxt_entry;
      CELL_CLEAR:   if (hit) entry_nxt = '0;
      CELL_WRITE: begin
        if (first_free) begin
          entry_nxt.mask    = ctl.key;
          entry_nxt.handler = ctl.hid;
        end
      end
      default:      entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

endmodule

`default_nettype wire
